@@ rtl/bcwb_pkg.sv @@
// Shared types, codes and range helpers for the bus cycle watch and break unit.
// Used by bcwb_cfg_regs, bcwb_eval and bus_cycle_watch_break_unit_core.
package bcwb_pkg;

  localparam int unsigned NUM_TYPES = 5;
  localparam int unsigned TYP_MEMRD = 0;
  localparam int unsigned TYP_MEMWR = 1;
  localparam int unsigned TYP_IORD  = 2;
  localparam int unsigned TYP_IOWR  = 3;
  localparam int unsigned TYP_FETCH = 4;

  localparam logic [2:0] CFG_MEMRD_RANGES = 3'd0;
  localparam logic [2:0] CFG_MEMWR_RANGES = 3'd1;
  localparam logic [2:0] CFG_IORD_RANGES  = 3'd2;
  localparam logic [2:0] CFG_IOWR_RANGES  = 3'd3;
  localparam logic [2:0] CFG_FETCH_RANGES = 3'd4;
  localparam logic [2:0] CFG_BREAK_COUNT  = 3'd5;
  localparam logic [2:0] CFG_FLAG_MASK    = 3'd6;

  localparam logic [63:0] RANGES_RESET    = 64'hFFFF_0000_FFFF_0000;
  localparam logic [7:0]  FLAG_MASK_RESET = 8'h03;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BUS   = 1'b1;

  localparam logic [7:0] OP_PREFIX_CB = 8'hCB;
  localparam logic [7:0] OP_PREFIX_DD = 8'hDD;
  localparam logic [7:0] OP_PREFIX_ED = 8'hED;
  localparam logic [7:0] OP_PREFIX_FD = 8'hFD;

  typedef enum logic [2:0] {
    RSN_NONE   = 3'd0,
    RSN_KEY    = 3'd1,
    RSN_SIGNAL = 3'd2,
    RSN_MEMRD  = 3'd3,
    RSN_MEMWR  = 3'd4,
    RSN_IORD   = 3'd5,
    RSN_IOWR   = 3'd6,
    RSN_FETCH  = 3'd7
  } bcwb_reason_t;

  typedef struct packed {
    logic [NUM_TYPES-1:0][63:0] ranges;
    logic [31:0]                break_count;
    logic [7:0]                 flag_mask;
  } bcwb_cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] bus_addr;
    logic [7:0]  bus_data;
    logic        is_io;
    logic        is_write;
    logic        is_fetch;
    logic [7:0]  status_flags;
    logic        stop_key;
  } bcwb_item_t;

  typedef struct packed {
    logic [NUM_TYPES-1:0] watch_hits;
    logic                 stop_now;
    bcwb_reason_t         stop_reason;
  } bcwb_result_t;

  function automatic logic watch_hit(input logic [63:0] r, input logic [15:0] a);
    return (r[63:48] <= a) && (a <= r[47:32]);
  endfunction

  function automatic logic break_hit(input logic [63:0] r, input logic [15:0] a);
    return (r[31:16] <= a) && (a <= r[15:0]);
  endfunction

  function automatic logic is_prefix(input logic [7:0] op);
    return (op == OP_PREFIX_CB) || (op == OP_PREFIX_DD) ||
           (op == OP_PREFIX_ED) || (op == OP_PREFIX_FD);
  endfunction

endpackage

@@ rtl/bcwb_cfg_regs.sv @@
// Configuration register file: range pairs per cycle type, break count, flag mask.
// Depends on bcwb_pkg.
module bcwb_cfg_regs
  import bcwb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  output bcwb_cfg_t   cfg
);

  bcwb_cfg_t cfg_r;
  bcwb_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_MEMRD_RANGES: cfg_nxt.ranges[TYP_MEMRD] = wr_data;
        CFG_MEMWR_RANGES: cfg_nxt.ranges[TYP_MEMWR] = wr_data;
        CFG_IORD_RANGES:  cfg_nxt.ranges[TYP_IORD]  = wr_data;
        CFG_IOWR_RANGES:  cfg_nxt.ranges[TYP_IOWR]  = wr_data;
        CFG_FETCH_RANGES: cfg_nxt.ranges[TYP_FETCH] = wr_data;
        CFG_BREAK_COUNT:  cfg_nxt.break_count       = wr_data[31:0];
        CFG_FLAG_MASK:    cfg_nxt.flag_mask         = wr_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        cfg_r.ranges[i] <= RANGES_RESET;
      end
      cfg_r.break_count <= '0;
      cfg_r.flag_mask   <= FLAG_MASK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/bcwb_eval.sv @@
// Per-transaction evaluation: stop checks, range compares, break countdown,
// prefix skip tracking. Holds the run state. Depends on bcwb_pkg.
module bcwb_eval
  import bcwb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         commit,
  input  bcwb_item_t   item,
  input  bcwb_cfg_t    cfg,
  output bcwb_result_t res
);

  logic [31:0] hits_left_r, hits_left_nxt;
  logic        stopped_r, stopped_nxt;
  logic        skip_r, skip_nxt;

  always_comb begin
    logic [15:0] io_addr;
    logic [31:0] hcur;
    logic        stop;
    io_addr       = {8'h00, item.bus_addr[7:0]};
    hcur          = hits_left_r;
    stop          = 1'b0;
    res           = '0;
    res.stop_reason = RSN_NONE;
    hits_left_nxt = hits_left_r;
    stopped_nxt   = stopped_r;
    skip_nxt      = skip_r;
    if (item.req_type == REQ_START) begin
      hits_left_nxt = (cfg.break_count != '0) ? cfg.break_count - 32'd1 : '0;
      stopped_nxt   = 1'b0;
    end else if (!stopped_r) begin
      priority if (item.stop_key) begin
        stop            = 1'b1;
        res.stop_reason = RSN_KEY;
      end else if ((item.status_flags & cfg.flag_mask) != cfg.flag_mask) begin
        stop            = 1'b1;
        res.stop_reason = RSN_SIGNAL;
      end else if (item.is_io && item.is_write) begin
        res.watch_hits[TYP_IOWR] = watch_hit(cfg.ranges[TYP_IOWR], io_addr);
        if (break_hit(cfg.ranges[TYP_IOWR], io_addr)) begin
          if (hcur == '0) begin
            stop            = 1'b1;
            res.stop_reason = RSN_IOWR;
          end else begin
            hcur = hcur - 32'd1;
          end
        end
      end else if (item.is_io) begin
        res.watch_hits[TYP_IORD] = watch_hit(cfg.ranges[TYP_IORD], io_addr);
        if (break_hit(cfg.ranges[TYP_IORD], io_addr)) begin
          if (hcur == '0) begin
            stop            = 1'b1;
            res.stop_reason = RSN_IORD;
          end else begin
            hcur = hcur - 32'd1;
          end
        end
      end else if (item.is_write) begin
        res.watch_hits[TYP_MEMWR] = watch_hit(cfg.ranges[TYP_MEMWR], item.bus_addr);
        if (break_hit(cfg.ranges[TYP_MEMWR], item.bus_addr)) begin
          if (hcur == '0) begin
            stop            = 1'b1;
            res.stop_reason = RSN_MEMWR;
          end else begin
            hcur = hcur - 32'd1;
          end
        end
      end else begin
        res.watch_hits[TYP_MEMRD] = watch_hit(cfg.ranges[TYP_MEMRD], item.bus_addr);
        if (item.is_fetch) begin
          if (!skip_r) begin
            res.watch_hits[TYP_FETCH] = watch_hit(cfg.ranges[TYP_FETCH], item.bus_addr);
            if (break_hit(cfg.ranges[TYP_FETCH], item.bus_addr)) begin
              if (hcur == '0) begin
                stop            = 1'b1;
                res.stop_reason = RSN_FETCH;
              end else begin
                hcur = hcur - 32'd1;
              end
            end
          end
          skip_nxt = is_prefix(item.bus_data);
        end
        if (!stop && break_hit(cfg.ranges[TYP_MEMRD], item.bus_addr)) begin
          if (hcur == '0) begin
            stop            = 1'b1;
            res.stop_reason = RSN_MEMRD;
          end else begin
            hcur = hcur - 32'd1;
          end
        end
      end
      hits_left_nxt = hcur;
      res.stop_now  = stop;
      if (stop) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_left_r <= '0;
      stopped_r   <= 1'b1;
      skip_r      <= 1'b0;
    end else if (commit) begin
      hits_left_r <= hits_left_nxt;
      stopped_r   <= stopped_nxt;
      skip_r      <= skip_nxt;
    end
  end

  a_stop_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    res.stop_now == (res.stop_reason != RSN_NONE))
    else $error("stop flag and stop reason disagree");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    commit && item.req_type == REQ_START |=> !stopped_r)
    else $error("start transaction did not arm");

  a_stop_latches: assert property (@(posedge clk) disable iff (!rst_n)
    commit && res.stop_now |=> stopped_r)
    else $error("stop did not latch");

  a_idle_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    commit && stopped_r && item.req_type == REQ_BUS
    |=> $stable(hits_left_r) && stopped_r && $stable(skip_r))
    else $error("state moved while stopped");

  a_key_no_watch: assert property (@(posedge clk) disable iff (!rst_n)
    res.stop_reason == RSN_KEY || res.stop_reason == RSN_SIGNAL
    |-> res.watch_hits == '0)
    else $error("watch hits reported on key or signal stop");

endmodule

@@ rtl/bus_cycle_watch_break_unit_core.sv @@
// Top level of the bus cycle watch and break unit: input register, evaluation,
// result register. Depends on bcwb_pkg, bcwb_cfg_regs and bcwb_eval.
//
// Usage:
//   Input channel (in_*): one transaction per monitored CPU bus cycle, or a
//   start transaction (in_req_type = 0) that arms the break countdown.
//   Result channel (out_*): exactly one result per input transaction, in order:
//   watch hits per cycle type, stop flag and stop reason.
//   Configuration channel (cfg_*): register index and 64-bit data; always ready.
//   Write it only while no transaction is in flight.
// Path: input register, then result register, then out_*. Throughput: one
//   transaction per cycle while out_ready is high. The input register and the
//   result register form a two-stage pipe; the run state updates when a
//   transaction leaves the input register, so back-to-back ones see each other.
// Reset (rst_n low, synchronous): pipe empty, block stopped until a start
//   transaction, countdown and prefix skip cleared, ranges empty, flag mask 3.
// Receiver stall: the result holds on out_*; one more transaction is still
//   taken into the input register, then in_ready drops until out_ready returns.
module bus_cycle_watch_break_unit_core
  import bcwb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_bus_addr,
  input  logic [7:0]  in_bus_data,
  input  logic        in_is_io,
  input  logic        in_is_write,
  input  logic        in_is_fetch,
  input  logic [7:0]  in_status_flags,
  input  logic        in_stop_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_watch_hits,
  output logic        out_stop_now,
  output logic [2:0]  out_stop_reason,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  bcwb_cfg_t    cfg;
  bcwb_item_t   item_r;
  logic         item_vld_r;
  bcwb_result_t res;
  bcwb_result_t res_r;
  logic         res_vld_r;
  logic         advance;
  logic         in_take;

  assign cfg_ready = 1'b1;
  assign advance   = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready  = !item_vld_r || advance;
  assign in_take   = in_valid && in_ready;

  bcwb_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bcwb_eval u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (item_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= in_take || (item_vld_r && !advance);
      res_vld_r  <= advance || (res_vld_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.req_type     <= in_req_type;
      item_r.bus_addr     <= in_bus_addr;
      item_r.bus_data     <= in_bus_data;
      item_r.is_io        <= in_is_io;
      item_r.is_write     <= in_is_write;
      item_r.is_fetch     <= in_is_fetch;
      item_r.status_flags <= in_status_flags;
      item_r.stop_key     <= in_stop_key;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid       = res_vld_r;
  assign out_watch_hits  = res_r.watch_hits;
  assign out_stop_now    = res_r.stop_now;
  assign out_stop_reason = res_r.stop_reason;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && !out_ready |-> !advance)
    else $error("result register overwritten while stalled");

  a_no_item_loss: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r && !advance |-> !in_ready)
    else $error("input register overwritten while held");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> res_vld_r)
    else $error("advanced transaction did not reach the result register");

endmodule
